>>> src/pairing_uri_stream_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pairing URI parser
// Each module that asserts supplies i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef PAIRING_URI_STREAM_PARSER_MACROS_SVH
`define PAIRING_URI_STREAM_PARSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define PUP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error("pup: same-cycle check failed");

// next-cycle implication, checked outside reset
`define PUP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error("pup: next-cycle check failed");

`endif

>>> src/pup_pkg.sv
// ----------------------------------------------------------------------------
// pup_pkg
// Types, constants and character tables shared by the URI parser modules.
// ----------------------------------------------------------------------------
package pup_pkg;

    localparam int HOST_MAX   = 64;
    localparam int TOKEN_MAX  = 128;
    localparam int HA_W       = $clog2(HOST_MAX);
    localparam int TOK_W      = $clog2(TOKEN_MAX);
    localparam int SCHEME_LEN = 11;
    localparam int TPFX_LEN   = 6;
    localparam int KEY_LEN    = 64;
    localparam int PORT_MAX   = 65535;

    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [1:0] {
        KIND_KEY     = 2'd0,
        KIND_TOKEN   = 2'd1,
        KIND_HOST    = 2'd2,
        KIND_VERDICT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SCHEME = 2'd1,
        ST_KEY    = 2'd2,
        ST_TAIL   = 2'd3
    } t_status;

    typedef enum logic [8:0] {
        S_SCHEME = 9'b000000001,
        S_KEY    = 9'b000000010,
        S_HOST   = 9'b000000100,
        S_TPFX   = 9'b000001000,
        S_TOKEN  = 9'b000010000,
        S_SINK   = 9'b000100000,
        S_RD     = 9'b001000000,
        S_EMIT   = 9'b010000000,
        S_VERD   = 9'b100000000
    } t_state;

    typedef struct packed {
        logic    cnt_inc;
        logic    cnt_clr;
        logic    key_emit;
        logic    tok_emit;
        logic    host_char;
        logic    host_emit;
        logic    verd_emit;
        logic    clear;
        logic    rd_clr;
        t_status verd_st;
    } t_dp_cmd;

    typedef struct packed {
        logic ch_zero;
        logic ch_at;
        logic ch_qmark;
        logic ch_hex;
        logic scheme_ok;
        logic scheme_done;
        logic tpfx_ok;
        logic tpfx_done;
        logic key_full;
        logic key_over;
        logic host_ok;
        logic colon_seen;
        logic lci_zero;
        logic rd_last;
        logic tok_full;
        logic tok_any;
        logic out_free;
    } t_dp_sts;

    function automatic logic [7:0] scheme_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h33;
            4'd1:    c = 8'h64;
            4'd2:    c = 8'h73;
            4'd3:    c = 8'h65;
            4'd4:    c = 8'h6E;
            4'd5:    c = 8'h64;
            4'd6:    c = 8'h61;
            4'd7:    c = 8'h69;
            4'd8:    c = 8'h3A;
            4'd9:    c = 8'h2F;
            4'd10:   c = 8'h2F;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "token="
    function automatic logic [7:0] tpfx_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h74;
            3'd1:    c = 8'h6F;
            3'd2:    c = 8'h6B;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h6E;
            3'd5:    c = 8'h3D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> src/pairing_uri_stream_parser.sv
// ----------------------------------------------------------------------------
// pairing_uri_stream_parser
// Streaming pairing-URI checker: scheme, 64-digit hex key, optional host:port
// and optional token, with a final verdict per string.
// ----------------------------------------------------------------------------
// Input channel: one character per transaction on i_ch (i_in_valid/o_in_ready);
// a zero character ends the string and returns the parser to its start state.
// Output channel: one result per transaction (o_out_valid/i_out_ready): key
// digits (lower case) and token characters as they arrive, then at the
// terminator the buffered host bytes, then the verdict with status and port.
// A key or token result is registered and appears in the cycle after its
// character. Throughput: one character per cycle while the result register
// is being drained; o_in_ready drops while that register is full and stalled
// and during the host drain. Terminator with a host part: each buffered host
// byte is read (S_RD), then loaded as a result (S_EMIT), then the verdict is
// loaded (S_VERD); no characters are taken in that drain. A receiver stall
// holds the result register and the sequencer. Reset clears all parse state;
// the host buffer needs no clearing: only current-string bytes are read back.
// ----------------------------------------------------------------------------
module pairing_uri_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_ch,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_byte_value,
    output logic [6:0]  o_position,
    output logic [15:0] o_port_number,
    output logic [1:0]  o_status,
    output logic        o_host_present,
    output logic        o_last_of_run
);
    import pup_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    pup_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pup_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ch           (i_ch),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_kind         (o_kind),
        .o_byte_value   (o_byte_value),
        .o_position     (o_position),
        .o_port_number  (o_port_number),
        .o_status       (o_status),
        .o_host_present (o_host_present),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

>>> src/pup_ctrl.sv
// ----------------------------------------------------------------------------
// pup_ctrl
// Parse-phase state machine and host-byte drain sequencer.
// ----------------------------------------------------------------------------
`include "pairing_uri_stream_parser_macros.svh"

module pup_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pup_pkg::t_dp_sts i_sts,
    output pup_pkg::t_dp_cmd o_cmd
);
    import pup_pkg::*;

    t_state  r_state, n_state;
    t_status r_err, n_err;
    t_status w_term_st;
    t_dp_cmd w_cmd;
    logic    w_parse;
    logic    w_acc;
    logic    w_drain;

    assign w_parse = (r_state == S_SCHEME) || (r_state == S_KEY) || (r_state == S_HOST) ||
                     (r_state == S_TPFX) || (r_state == S_TOKEN) || (r_state == S_SINK);
    assign o_in_ready = w_parse && i_sts.out_free;
    assign w_acc      = i_in_valid && o_in_ready;
    assign o_cmd      = w_cmd;

    always_comb begin
        unique case (r_state)
            S_SCHEME: w_term_st = ST_SCHEME;
            S_KEY:    w_term_st = i_sts.key_full ? ST_OK : ST_KEY;
            S_HOST:   w_term_st = i_sts.host_ok ? ST_OK : ST_TAIL;
            S_TPFX:   w_term_st = ST_TAIL;
            S_TOKEN:  w_term_st = i_sts.tok_any ? ST_OK : ST_TAIL;
            S_SINK:   w_term_st = r_err;
            default:  w_term_st = ST_OK;
        endcase
    end

    assign w_drain = (w_term_st == ST_OK) && i_sts.colon_seen && !i_sts.lci_zero;

    always_comb begin
        n_state = r_state;
        n_err   = r_err;
        w_cmd   = '0;
        if (w_acc && i_sts.ch_zero) begin
            if (w_drain) begin
                w_cmd.rd_clr = 1'b1;
                n_state      = S_RD;
            end else begin
                w_cmd.verd_emit = 1'b1;
                w_cmd.verd_st   = w_term_st;
                w_cmd.clear     = 1'b1;
                n_err           = ST_OK;
                n_state         = S_SCHEME;
            end
        end else begin
            unique case (r_state)
                S_SCHEME: begin
                    if (w_acc) begin
                        if (i_sts.scheme_ok) begin
                            w_cmd.cnt_inc = 1'b1;
                            if (i_sts.scheme_done) begin
                                w_cmd.cnt_clr = 1'b1;
                                n_state       = S_KEY;
                            end
                        end else begin
                            n_err   = ST_SCHEME;
                            n_state = S_SINK;
                        end
                    end
                end
                S_KEY: begin
                    if (w_acc) begin
                        if (i_sts.ch_at || i_sts.ch_qmark) begin
                            if (i_sts.key_full) begin
                                w_cmd.cnt_clr = 1'b1;
                                n_state       = i_sts.ch_at ? S_HOST : S_TPFX;
                            end else begin
                                n_err   = ST_KEY;
                                n_state = S_SINK;
                            end
                        end else if (i_sts.key_over || !i_sts.ch_hex) begin
                            n_err   = ST_KEY;
                            n_state = S_SINK;
                        end else begin
                            w_cmd.key_emit = 1'b1;
                            w_cmd.cnt_inc  = 1'b1;
                        end
                    end
                end
                S_HOST: begin
                    if (w_acc) begin
                        if (i_sts.ch_qmark) begin
                            if (i_sts.host_ok) begin
                                w_cmd.cnt_clr = 1'b1;
                                n_state       = S_TPFX;
                            end else begin
                                n_err   = ST_TAIL;
                                n_state = S_SINK;
                            end
                        end else begin
                            w_cmd.host_char = 1'b1;
                        end
                    end
                end
                S_TPFX: begin
                    if (w_acc) begin
                        if (i_sts.tpfx_ok) begin
                            w_cmd.cnt_inc = 1'b1;
                            if (i_sts.tpfx_done) begin
                                n_state = S_TOKEN;
                            end
                        end else begin
                            n_err   = ST_TAIL;
                            n_state = S_SINK;
                        end
                    end
                end
                S_TOKEN: begin
                    if (w_acc) begin
                        if (i_sts.tok_full) begin
                            n_err   = ST_TAIL;
                            n_state = S_SINK;
                        end else begin
                            w_cmd.tok_emit = 1'b1;
                        end
                    end
                end
                S_SINK: begin
                    // drop everything up to the terminator
                end
                S_RD: begin
                    n_state = S_EMIT;
                end
                S_EMIT: begin
                    if (i_sts.out_free) begin
                        w_cmd.host_emit = 1'b1;
                        n_state         = i_sts.rd_last ? S_VERD : S_RD;
                    end
                end
                S_VERD: begin
                    if (i_sts.out_free) begin
                        w_cmd.verd_emit = 1'b1;
                        w_cmd.verd_st   = ST_OK;
                        w_cmd.clear     = 1'b1;
                        n_err           = ST_OK;
                        n_state         = S_SCHEME;
                    end
                end
                default: begin
                    n_state = S_SCHEME;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SCHEME;
            r_err   <= ST_OK;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
        end
    end

    `PUP_ASSERT_IMP(a_no_accept_in_drain,
        (r_state == S_RD) || (r_state == S_EMIT) || (r_state == S_VERD), !o_in_ready)
    `PUP_ASSERT_NXT(a_read_then_emit, r_state == S_RD, r_state == S_EMIT)
    `PUP_ASSERT_IMP(a_sink_has_error, r_state == S_SINK, r_err != ST_OK)

endmodule

>>> src/pup_dp.sv
// ----------------------------------------------------------------------------
// pup_dp
// Counters, host buffer, port accumulator and the result register.
// ----------------------------------------------------------------------------
`include "pairing_uri_stream_parser_macros.svh"

module pup_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_ch,
    input  pup_pkg::t_dp_cmd i_cmd,
    output pup_pkg::t_dp_sts o_sts,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_byte_value,
    output logic [6:0]       o_position,
    output logic [15:0]      o_port_number,
    output logic [1:0]       o_status,
    output logic             o_host_present,
    output logic             o_last_of_run
);
    import pup_pkg::*;

    logic [6:0]       r_cnt;
    logic [6:0]       r_span;
    logic [6:0]       r_lci;
    logic             r_colon;
    logic [16:0]      r_accum;
    logic             r_pvalid;
    logic [TOK_W-1:0] r_tc;
    logic [6:0]       r_rd_idx;
    logic [7:0]       r_mem [HOST_MAX];
    logic [7:0]       r_rd_q;

    logic             r_out_valid;
    t_kind            r_kind;
    logic [7:0]       r_byte;
    logic [6:0]       r_pos;
    logic [15:0]      r_port;
    t_status          r_status;
    logic             r_hp;
    logic             r_last;

    logic             w_digit;
    logic [20:0]      w_prod;
    logic             w_wr;
    logic             w_out_free;
    logic             w_verd_hp;
    logic [7:0]       w_lc;

    assign w_digit    = (i_ch >= 8'h30) && (i_ch <= 8'h39);
    assign w_prod     = 21'(r_accum) * 21'd10 + {17'd0, i_ch[3:0]};
    assign w_wr       = i_cmd.host_char && (r_span < 7'(HOST_MAX));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_verd_hp  = (i_cmd.verd_st == ST_OK) && r_colon;
    assign w_lc       = ((i_ch >= 8'h41) && (i_ch <= 8'h46)) ? (i_ch | 8'h20) : i_ch;

    always_comb begin
        o_sts             = '0;
        o_sts.ch_zero     = (i_ch == 8'h00);
        o_sts.ch_at       = (i_ch == CH_AT);
        o_sts.ch_qmark    = (i_ch == CH_QMARK);
        o_sts.ch_hex      = w_digit || ((i_ch >= 8'h61) && (i_ch <= 8'h66)) ||
                            ((i_ch >= 8'h41) && (i_ch <= 8'h46));
        o_sts.scheme_ok   = (r_cnt < 7'(SCHEME_LEN)) && (i_ch == scheme_char(r_cnt[3:0]));
        o_sts.scheme_done = (r_cnt == 7'(SCHEME_LEN - 1));
        o_sts.tpfx_ok     = (r_cnt < 7'(TPFX_LEN)) && (i_ch == tpfx_char(r_cnt[2:0]));
        o_sts.tpfx_done   = (r_cnt == 7'(TPFX_LEN - 1));
        o_sts.key_full    = (r_cnt == 7'(KEY_LEN));
        o_sts.key_over    = (r_cnt >= 7'(KEY_LEN));
        o_sts.host_ok     = r_colon && r_pvalid && (r_accum >= 17'd1) &&
                            (r_accum <= 17'(PORT_MAX)) && (r_lci >= 7'd1) &&
                            (r_lci < 7'(HOST_MAX));
        o_sts.colon_seen  = r_colon;
        o_sts.lci_zero    = (r_lci == 7'd0);
        o_sts.rd_last     = ((r_rd_idx + 7'd1) == r_lci);
        o_sts.tok_full    = (r_tc == TOK_W'(TOKEN_MAX - 1));
        o_sts.tok_any     = (r_tc != '0);
        o_sts.out_free    = w_out_free;
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_cnt    <= '0;
            r_span   <= '0;
            r_lci    <= '0;
            r_colon  <= 1'b0;
            r_accum  <= '0;
            r_pvalid <= 1'b0;
            r_tc     <= '0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 7'd1;
            end
            if (i_cmd.tok_emit) begin
                r_tc <= r_tc + TOK_W'(1);
            end
            if (i_cmd.host_char) begin
                if (r_span != 7'd127) begin
                    r_span <= r_span + 7'd1;
                end
                if (i_ch == CH_COLON) begin
                    r_colon  <= 1'b1;
                    r_lci    <= r_span;
                    r_accum  <= '0;
                    r_pvalid <= 1'b1;
                end else if (r_colon) begin
                    if (r_pvalid && w_digit) begin
                        if (w_prod > 21'(PORT_MAX)) begin
                            r_pvalid <= 1'b0;
                            r_accum  <= 17'(PORT_MAX + 1);
                        end else begin
                            r_accum <= w_prod[16:0];
                        end
                    end else begin
                        r_pvalid <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
        end else if (i_cmd.rd_clr) begin
            r_rd_idx <= '0;
        end else if (i_cmd.host_emit) begin
            r_rd_idx <= r_rd_idx + 7'd1;
        end
    end

    // host buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_span[HA_W-1:0]] <= i_ch;
        end
        r_rd_q <= r_mem[r_rd_idx[HA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.key_emit || i_cmd.tok_emit || i_cmd.host_emit ||
                     i_cmd.verd_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_emit) begin
            r_kind   <= KIND_KEY;
            r_byte   <= w_lc;
            r_pos    <= r_cnt;
            r_port   <= '0;
            r_status <= ST_OK;
            r_hp     <= 1'b0;
            r_last   <= 1'b1;
        end else if (i_cmd.tok_emit) begin
            r_kind   <= KIND_TOKEN;
            r_byte   <= i_ch;
            r_pos    <= 7'(r_tc);
            r_port   <= '0;
            r_status <= ST_OK;
            r_hp     <= 1'b0;
            r_last   <= 1'b1;
        end else if (i_cmd.host_emit) begin
            r_kind   <= KIND_HOST;
            r_byte   <= r_rd_q;
            r_pos    <= r_rd_idx;
            r_port   <= '0;
            r_status <= ST_OK;
            r_hp     <= 1'b0;
            r_last   <= 1'b0;
        end else if (i_cmd.verd_emit) begin
            r_kind   <= KIND_VERDICT;
            r_byte   <= '0;
            r_pos    <= '0;
            r_port   <= w_verd_hp ? r_accum[15:0] : 16'd0;
            r_status <= i_cmd.verd_st;
            r_hp     <= w_verd_hp;
            r_last   <= 1'b1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_byte_value   = r_byte;
    assign o_position     = r_pos;
    assign o_port_number  = r_port;
    assign o_status       = r_status;
    assign o_host_present = r_hp;
    assign o_last_of_run  = r_last;

    `PUP_ASSERT_IMP(a_load_needs_room,
        i_cmd.key_emit || i_cmd.tok_emit || i_cmd.host_emit || i_cmd.verd_emit, w_out_free)
    `PUP_ASSERT_IMP(a_one_load,
        1'b1, $onehot0({i_cmd.key_emit, i_cmd.tok_emit, i_cmd.host_emit, i_cmd.verd_emit}))
    `PUP_ASSERT_IMP(a_port_in_range, r_pvalid, r_accum <= 17'(PORT_MAX))

endmodule

>>> tb/sv/pairing_uri_stream_parser_tb.sv
// ----------------------------------------------------------------------------
// pairing_uri_stream_parser_tb
// Self-checking bench for the streaming pairing-URI parser. A scoreboard
// class predicts every result from the accepted characters and checks the
// output stream in order. Directed strings cover truncation, key, host:port
// and token corner cases. Random strings follow, mostly well formed with
// random content and some corrupted, cut short or pure noise. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module pairing_uri_stream_parser_tb;

    import pup_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 4;
    localparam int ITEM_BUDGET    = 400;
    localparam int KEY_SWEEP      = 22;
    localparam int TAIL_CYCLES    = 16;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    localparam logic [7:0] CH_END = 8'h00;

    // scheme prefix bytes, first character in the top byte
    localparam logic [8*SCHEME_LEN-1:0] URI_PREFIX = 88'h33_64_73_65_6E_64_61_69_3A_2F_2F;
    localparam logic [8*TPFX_LEN-1:0]   TOKEN_TAG  = "token=";

    typedef logic [7:0] char_q_t [$];

    typedef enum logic [2:0] {
        PP_SCHEME,
        PP_KEY,
        PP_HOST,
        PP_TPFX,
        PP_TOKEN,
        PP_SINK
    } parse_phase_e;

    typedef struct {
        t_kind       kind;
        logic [7:0]  byte_value;
        logic [6:0]  position;
        logic [15:0] port_number;
        t_status     status;
        logic        host_present;
        logic        last_of_run;
    } uri_result_t;

    class uri_scoreboard;
        parse_phase_e phase;
        logic [7:0]   char_count;
        logic [7:0]   host_bytes [HOST_MAX];
        logic [6:0]   host_len;
        logic [6:0]   colon_at;
        bit           colon_seen;
        logic [16:0]  port_acc;
        bit           port_ok;
        logic [7:0]   token_len;
        t_status      first_error;
        uri_result_t  pending [$];
        int           mismatches;

        function new();
            restart();
            mismatches = 0;
        endfunction

        function void restart();
            phase       = PP_SCHEME;
            char_count  = '0;
            host_len    = '0;
            colon_at    = '0;
            colon_seen  = 1'b0;
            port_acc    = '0;
            port_ok     = 1'b0;
            token_len   = '0;
            first_error = ST_OK;
        endfunction

        function void fail_with(t_status code);
            first_error = code;
            phase       = PP_SINK;
        endfunction

        function bit host_port_ok();
            return colon_seen && port_ok && port_acc >= 1 && port_acc <= PORT_MAX &&
                   colon_at >= 1 && colon_at < HOST_MAX;
        endfunction

        function void add_result(t_kind kind, logic [7:0] value, logic [6:0] pos,
                                 logic [15:0] port, t_status st, bit hp, bit last);
            uri_result_t r;
            r.kind         = kind;
            r.byte_value   = value;
            r.position     = pos;
            r.port_number  = port;
            r.status       = st;
            r.host_present = hp;
            r.last_of_run  = last;
            pending.push_back(r);
        endfunction

        // Advance the parse by one accepted character and queue what it emits.
        function void note_char(logic [7:0] c);
            t_status     verdict;
            logic [15:0] port;
            bit          with_host;
            int          digit_sum;
            logic [6:0]  slot;
            logic [7:0]  folded;

            if (c == CH_END) begin
                case (phase)
                    PP_SCHEME: verdict = ST_SCHEME;
                    PP_KEY:    verdict = (char_count == KEY_LEN) ? ST_OK : ST_KEY;
                    PP_HOST:   verdict = host_port_ok() ? ST_OK : ST_TAIL;
                    PP_TPFX:   verdict = ST_TAIL;
                    PP_TOKEN:  verdict = (token_len > 0) ? ST_OK : ST_TAIL;
                    default:   verdict = first_error;
                endcase
                port      = '0;
                with_host = 1'b0;
                if (verdict == ST_OK && colon_seen) begin
                    for (int i = 0; i < colon_at && i < HOST_MAX; i++) begin
                        add_result(KIND_HOST, host_bytes[i], i[6:0], '0, ST_OK, 1'b0, 1'b0);
                    end
                    port      = port_acc[15:0];
                    with_host = 1'b1;
                end
                add_result(KIND_VERDICT, '0, '0, port, verdict, with_host, 1'b1);
                restart();
                return;
            end

            case (phase)
                PP_SCHEME: begin
                    if (char_count < SCHEME_LEN &&
                        c == URI_PREFIX[8*(SCHEME_LEN-1-char_count) +: 8]) begin
                        char_count++;
                        if (char_count == SCHEME_LEN) begin
                            phase      = PP_KEY;
                            char_count = '0;
                        end
                    end else begin
                        fail_with(ST_SCHEME);
                    end
                end
                PP_KEY: begin
                    if (c == CH_AT || c == CH_QMARK) begin
                        if (char_count != KEY_LEN) begin
                            fail_with(ST_KEY);
                        end else begin
                            phase      = (c == CH_AT) ? PP_HOST : PP_TPFX;
                            char_count = '0;
                        end
                    end else if (char_count >= KEY_LEN ||
                                 !((c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
                                   (c >= "A" && c <= "F"))) begin
                        fail_with(ST_KEY);
                    end else begin
                        folded = (c >= "A" && c <= "F") ? c + 8'h20 : c;
                        add_result(KIND_KEY, folded, char_count[6:0], '0, ST_OK, 1'b0, 1'b1);
                        char_count++;
                    end
                end
                PP_HOST: begin
                    if (c == CH_QMARK) begin
                        if (host_port_ok()) begin
                            phase      = PP_TPFX;
                            char_count = '0;
                        end else begin
                            fail_with(ST_TAIL);
                        end
                    end else begin
                        slot = host_len;
                        // count bytes past the buffer, but drop them
                        if (slot < HOST_MAX) host_bytes[slot] = c;
                        if (host_len < 127) host_len++;
                        if (c == CH_COLON) begin
                            colon_seen = 1'b1;
                            colon_at   = slot;
                            port_acc   = '0;
                            port_ok    = 1'b1;
                        end else if (colon_seen) begin
                            if (port_ok && c >= "0" && c <= "9") begin
                                digit_sum = int'(port_acc) * 10 + int'(c - "0");
                                if (digit_sum > PORT_MAX) begin
                                    port_ok  = 1'b0;
                                    port_acc = PORT_MAX + 1;
                                end else begin
                                    port_acc = digit_sum[16:0];
                                end
                            end else begin
                                port_ok = 1'b0;
                            end
                        end
                    end
                end
                PP_TPFX: begin
                    if (char_count < TPFX_LEN &&
                        c == TOKEN_TAG[8*(TPFX_LEN-1-char_count) +: 8]) begin
                        char_count++;
                        if (char_count == TPFX_LEN) phase = PP_TOKEN;
                    end else begin
                        fail_with(ST_TAIL);
                    end
                end
                PP_TOKEN: begin
                    if (token_len + 1 >= TOKEN_MAX) begin
                        fail_with(ST_TAIL);
                    end else begin
                        add_result(KIND_TOKEN, c, token_len[6:0], '0, ST_OK, 1'b0, 1'b1);
                        token_len++;
                    end
                end
                default: begin
                    // drop everything until the terminator
                end
            endcase
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(uri_result_t got);
            uri_result_t want;
            if (pending.size() == 0) begin
                $error("result with none pending: kind %0d, byte_value %0h",
                       got.kind, got.byte_value);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            compare_field("kind",         want.kind,         got.kind);
            compare_field("byte_value",   want.byte_value,   got.byte_value);
            compare_field("position",     want.position,     got.position);
            compare_field("port_number",  want.port_number,  got.port_number);
            compare_field("status",       want.status,       got.status);
            compare_field("host_present", want.host_present, got.host_present);
            compare_field("last_of_run",  want.last_of_run,  got.last_of_run);
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_ch        = 8'h00;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_byte_value;
    logic [6:0]  o_position;
    logic [15:0] o_port_number;
    logic [1:0]  o_status;
    logic        o_host_present;
    logic        o_last_of_run;

    bit          quiet_in   = 1'b0;
    bit          quiet_out  = 1'b0;
    int          sent_items = 0;
    uri_result_t seen;

    uri_scoreboard sb = new();

    pairing_uri_stream_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_ch           (i_ch),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_byte_value   (o_byte_value),
        .o_position     (o_position),
        .o_port_number  (o_port_number),
        .o_status       (o_status),
        .o_host_present (o_host_present),
        .o_last_of_run  (o_last_of_run)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Sample both channels on the edge, before any register update lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_char(i_ch);
            if (o_out_valid && i_out_ready) begin
                seen.kind         = t_kind'(o_kind);
                seen.byte_value   = o_byte_value;
                seen.position     = o_position;
                seen.port_number  = o_port_number;
                seen.status       = t_status'(o_status);
                seen.host_present = o_host_present;
                seen.last_of_run  = o_last_of_run;
                sb.check_result(seen);
            end
        end
    end

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch       <= c;
        do @(posedge i_clk); while (!o_in_ready);
        sent_items++;
    endtask

    task automatic send_uri(input char_q_t body);
        quiet_in  = ($urandom_range(0, 3) == 0);
        quiet_out = ($urandom_range(0, 3) == 0);
        foreach (body[i]) send_char(body[i]);
        send_char(CH_END);
    endtask

    // Hold the sender until every pending result has been seen.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic put_text(ref char_q_t q, input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endtask

    task automatic put_prefix(ref char_q_t q, input int n);
        for (int i = 0; i < n; i++) q.push_back(URI_PREFIX[8*(SCHEME_LEN-1-i) +: 8]);
    endtask

    task automatic put_key(ref char_q_t q, input int n, input bit sweep);
        string hex_set;
        hex_set = "0123456789abcdefABCDEF";
        for (int i = 0; i < n; i++) begin
            q.push_back(sweep ? hex_set[i % 22] : hex_set[$urandom_range(0, 21)]);
        end
    endtask

    task automatic put_valid_head(ref char_q_t q);
        put_prefix(q, SCHEME_LEN);
        put_key(q, KEY_LEN, 1'b0);
    endtask

    // host bytes with no separator in them; colons are placed explicitly
    task automatic put_host(ref char_q_t q, input int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            do c = $urandom_range(1, 255); while (c == CH_QMARK || c == CH_COLON);
            q.push_back(c);
        end
    endtask

    task automatic put_token(ref char_q_t q, input int n);
        for (int i = 0; i < n; i++) q.push_back($urandom_range(1, 255));
    endtask

    task automatic put_port(ref char_q_t q, input int port);
        put_text(q, $sformatf("%0d", port));
    endtask

    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = quiet_out ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin : stimulus
        char_q_t body;
        int      roll;
        int      cut;
        int      port;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // terminator alone, wrong first character, prefix cut short
        body.delete();
        send_uri(body);
        body.delete();
        put_text(body, "X");
        put_key(body, 10, 1'b0);
        send_uri(body);
        body.delete();
        put_prefix(body, 7);
        send_uri(body);

        // short key sweeping every hex digit in both cases, then a non-hex digit
        body.delete();
        put_prefix(body, SCHEME_LEN);
        put_key(body, KEY_SWEEP, 1'b1);
        body.push_back(CH_AT);
        send_uri(body);
        body.delete();
        put_prefix(body, SCHEME_LEN);
        put_key(body, 10, 1'b0);
        put_text(body, "g12");
        send_uri(body);

        // host with a later colon restarting the port, then a one-character token
        body.delete();
        put_valid_head(body);
        put_text(body, "@a:1:80?token=x");
        send_uri(body);
        drain_results();

        while (sent_items < ITEM_BUDGET) begin
            body.delete();
            put_valid_head(body);
            if ($urandom_range(0, 1) == 1) begin
                body.push_back(CH_AT);
                put_host(body, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 70)
                                                           : $urandom_range(1, 10));
                if ($urandom_range(0, 4) == 0) begin
                    body.push_back(CH_COLON);
                    put_host(body, $urandom_range(1, 3));
                end
                body.push_back(CH_COLON);
                case ($urandom_range(0, 9))
                    0:       port = 0;
                    1:       port = PORT_MAX;
                    2:       port = PORT_MAX + 1;
                    3:       port = 1;
                    4:       port = $urandom_range(PORT_MAX + 1, 999999);
                    default: port = $urandom_range(1, PORT_MAX);
                endcase
                put_port(body, port);
                if ($urandom_range(0, 9) == 0) put_host(body, 1);
            end
            if ($urandom_range(0, 1) == 1) begin
                body.push_back(CH_QMARK);
                put_text(body, "token=");
                put_token(body, ($urandom_range(0, 9) == 0) ? $urandom_range(120, 130)
                                                            : $urandom_range(1, 16));
            end
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                body[$urandom_range(0, body.size() - 1)] = $urandom_range(1, 255);
            end else if (roll < 30) begin
                cut = $urandom_range(0, body.size());
                while (body.size() > cut) void'(body.pop_back());
            end else if (roll < 40) begin
                body.delete();
                put_token(body, $urandom_range(1, 24));
            end
            send_uri(body);
            if ($urandom_range(0, 7) == 0) drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/pup_pkg.sv
src/pup_ctrl.sv
src/pup_dp.sv
src/pairing_uri_stream_parser.sv
tb/sv/pairing_uri_stream_parser_tb.sv
